/* rtl/core/skt_pkg.sv */
// skt_pkg: shared types and codes for the sorted key table.
// No dependencies.
`timescale 1ns / 1ps
package skt_pkg;
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SORT   = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RSVD      = 2'd3
   } status_type;

   // datapath operations requested by the controller
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_INSERT,
      OP_SORT_INIT,
      OP_BUILD_NEXT,
      OP_SIFT_START,
      OP_SIFT_LATCH,
      OP_SIFT_RD_HOLD,
      OP_SIFT_RD_CHILD,
      OP_SIFT_RD_RIGHT,
      OP_SIFT_CMP,
      OP_SIFT_PLACE,
      OP_SWAP_RD,
      OP_SWAP_WR0,
      OP_SWAP_WRI,
      OP_FIND_INIT,
      OP_FIND_RD,
      OP_FIND_CMP
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic full;
      logic small_table;   // fewer than two entries
      logic build_done;    // heap build finished
      logic extract_done;  // extraction finished
      logic sift_has_child;
      logic sift_move;     // hold moves below chosen child
      logic find_active;   // probe inside window
      logic find_hit;
   } sts_type;
endpackage

/* rtl/core/skt_ram.sv */
// skt_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* rtl/core/skt_datapath.sv */
// skt_datapath: table memories, index registers and compares.
// Depends on skt_pkg and skt_ram.
`timescale 1ns / 1ps
module skt_datapath #(
   parameter int CAPACITY = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  skt_pkg::ctl_type        ctl,
   input  logic signed [31:0]      req_key,
   input  logic [31:0]             req_payload,
   output skt_pkg::sts_type        sts,
   output logic [31:0]             found_payload
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] len_ff, len_in;      // heap size for current sift
   logic [CW-1:0] build_ff, build_in;  // build index + 1
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] child_ff, child_in;
   logic [CW-1:0] left_ff, left_in, right_ff, right_in, probe_ff, probe_in;
   logic [31:0]   hold_key_ff, hold_key_in, hold_pay_ff, hold_pay_in;
   logic [31:0]   ckey_ff, ckey_in, cpay_ff, cpay_in;
   logic signed [31:0] key_ff, key_in;  // search key of the current find
   logic          rd_second_ff, rd_second_in;
   logic          extract_ff, extract_in;

   logic          wr_en;
   logic [CW-1:0] addr;
   logic [31:0]   wr_key, wr_pay, rd_key, rd_pay;

   skt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_keys (
      .clock(clock), .wr_en(wr_en), .addr(addr[AW-1:0]),
      .wr_data(wr_key), .rd_data(rd_key));
   skt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_pays (
      .clock(clock), .wr_en(wr_en), .addr(addr[AW-1:0]),
      .wr_data(wr_pay), .rd_data(rd_pay));

   logic [CW:0] lchild, rchild;
   logic        key_lt;
   assign lchild = {pos_ff, 1'b1};
   assign rchild = lchild + 1'b1;
   assign key_lt = $signed(ckey_ff) < $signed(rd_key);

   always_comb begin
      count_in     = count_ff;
      len_in       = len_ff;
      build_in     = build_ff;
      pos_in       = pos_ff;
      child_in     = child_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      probe_in     = probe_ff;
      hold_key_in  = hold_key_ff;
      hold_pay_in  = hold_pay_ff;
      ckey_in      = ckey_ff;
      cpay_in      = cpay_ff;
      key_in       = key_ff;
      rd_second_in = rd_second_ff;
      extract_in   = extract_ff;
      wr_en        = 1'b0;
      addr         = pos_ff;
      wr_key       = hold_key_ff;
      wr_pay       = hold_pay_ff;
      unique case (ctl.op)
         skt_pkg::OP_INSERT: begin
            addr     = count_ff;
            wr_en    = 1'b1;
            wr_key   = req_key;
            wr_pay   = req_payload;
            count_in = count_ff + 1'b1;
         end
         skt_pkg::OP_SORT_INIT: begin
            build_in   = CW'(count_ff >> 1) + 1'b1;
            len_in     = count_ff;
            extract_in = 1'b0;
         end
         skt_pkg::OP_BUILD_NEXT: begin
            build_in = build_ff - 1'b1;
            pos_in   = build_ff - 1'b1;
         end
         skt_pkg::OP_SIFT_START: begin
            addr = pos_ff;  // read hold entry
         end
         skt_pkg::OP_SIFT_LATCH: begin
            hold_key_in = rd_key;
            hold_pay_in = rd_pay;
         end
         skt_pkg::OP_SIFT_RD_HOLD: begin
            addr         = lchild[CW-1:0];
            child_in     = lchild[CW-1:0];
            rd_second_in = 1'b0;
         end
         skt_pkg::OP_SIFT_RD_CHILD: begin
            // latch left child, issue right read if present
            ckey_in      = rd_key;
            cpay_in      = rd_pay;
            rd_second_in = 1'b0;
            if (rchild < {1'b0, len_ff}) begin
               addr         = rchild[CW-1:0];
               rd_second_in = 1'b1;
            end
         end
         skt_pkg::OP_SIFT_RD_RIGHT: begin
            rd_second_in = 1'b0;
            if (rd_second_ff && key_lt) begin
               ckey_in  = rd_key;
               cpay_in  = rd_pay;
               child_in = rchild[CW-1:0];
            end
         end
         skt_pkg::OP_SIFT_CMP: begin
            // move child up into pos
            addr   = pos_ff;
            wr_en  = 1'b1;
            wr_key = ckey_ff;
            wr_pay = cpay_ff;
            pos_in = child_ff;
         end
         skt_pkg::OP_SIFT_PLACE: begin
            addr  = pos_ff;
            wr_en = 1'b1;
         end
         skt_pkg::OP_SWAP_RD: begin
            // read root into hold; later write last into root
            if (!rd_second_ff) begin
               addr         = '0;
               rd_second_in = 1'b1;
               len_in       = extract_ff ? len_ff - 1'b1 : len_ff - 1'b1;
               extract_in   = 1'b1;
            end else begin
               addr         = len_ff;
               hold_key_in  = rd_key;
               hold_pay_in  = rd_pay;
               rd_second_in = 1'b0;
            end
         end
         skt_pkg::OP_SWAP_WR0: begin
            addr   = '0;
            wr_en  = 1'b1;
            wr_key = rd_key;
            wr_pay = rd_pay;
         end
         skt_pkg::OP_SWAP_WRI: begin
            addr   = len_ff;
            wr_en  = 1'b1;
            pos_in = '0;
         end
         skt_pkg::OP_FIND_INIT: begin
            left_in  = '0;
            right_in = count_ff;
            probe_in = CW'(count_ff >> 1);
            key_in   = req_key;
         end
         skt_pkg::OP_FIND_RD: begin
            addr = probe_ff;
         end
         skt_pkg::OP_FIND_CMP: begin
            if ($signed(rd_key) < key_ff) begin
               left_in  = probe_ff + 1'b1;
               probe_in = CW'(({1'b0, probe_ff} + {1'b0, right_ff}) >> 1);
            end else begin
               right_in = probe_ff;
               probe_in = CW'(({1'b0, left_ff} + {1'b0, probe_ff}) >> 1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_second_ff <= 1'b0;
         extract_ff   <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_second_ff <= rd_second_in;
         extract_ff   <= extract_in;
      end
      len_ff      <= len_in;
      build_ff    <= build_in;
      pos_ff      <= pos_in;
      child_ff    <= child_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      probe_ff    <= probe_in;
      hold_key_ff <= hold_key_in;
      hold_pay_ff <= hold_pay_in;
      ckey_ff     <= ckey_in;
      cpay_ff     <= cpay_in;
      key_ff      <= key_in;
   end

   assign sts.full           = (count_ff == CW'(CAPACITY));
   assign sts.small_table    = (count_ff < CW'(2));
   assign sts.build_done     = (build_ff == '0);
   assign sts.extract_done   = (len_ff <= CW'(1));
   assign sts.sift_has_child = (lchild < {1'b0, len_ff});
   assign sts.sift_move      = $signed(hold_key_ff) < $signed(ckey_ff);
   assign sts.find_active    = (probe_ff >= left_ff) && (probe_ff < right_ff);
   assign sts.find_hit       = (rd_key == key_ff);
   assign found_payload      = rd_pay;
endmodule

/* rtl/core/skt_ctrl.sv */
// skt_ctrl: command sequencer for insert, heap sort and search.
// Depends on skt_pkg.
`timescale 1ns / 1ps
module skt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_found_payload,
   input  logic [31:0]       found_payload,
   input  skt_pkg::sts_type  sts,
   output skt_pkg::ctl_type  ctl
);
   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_BUILD    = 15'b000000000000010,
      S_SIFT_ST  = 15'b000000000000100,
      S_SIFT_HLD = 15'b000000000001000,
      S_SIFT_CH  = 15'b000000000010000,
      S_SIFT_CH2 = 15'b000000000100000,
      S_SIFT_DEC = 15'b000000001000000,
      S_SIFT_PL  = 15'b000000010000000,
      S_SWAP_R0  = 15'b000000100000000,
      S_SWAP_R1  = 15'b000001000000000,
      S_SWAP_W0  = 15'b000010000000000,
      S_SWAP_WI  = 15'b000100000000000,
      S_FIND_RD  = 15'b001000000000000,
      S_FIND_CMP = 15'b010000000000000,
      S_SIFT_LD  = 15'b100000000000000
   } state_type;

   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] pay_ff, pay_in;
   logic        extract_ff, extract_in;
   logic        done;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      pay_in       = pay_ff;
      extract_in   = extract_ff;
      ctl.op       = skt_pkg::OP_IDLE;
      done         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               status_in = skt_pkg::ST_OK;
               pay_in    = '0;
               unique case (skt_pkg::cmd_type'(req_cmd))
                  skt_pkg::CMD_INSERT: begin
                     done = 1'b1;
                     if (sts.full) begin
                        status_in = skt_pkg::ST_FULL;
                     end else begin
                        ctl.op = skt_pkg::OP_INSERT;
                     end
                  end
                  skt_pkg::CMD_SORT: begin
                     if (sts.small_table) begin
                        done = 1'b1;
                     end else begin
                        ctl.op     = skt_pkg::OP_SORT_INIT;
                        extract_in = 1'b0;
                        state_in   = S_BUILD;
                     end
                  end
                  skt_pkg::CMD_FIND: begin
                     ctl.op   = skt_pkg::OP_FIND_INIT;
                     state_in = S_FIND_RD;
                  end
                  default: done = 1'b1;
               endcase
            end
         end
         S_BUILD: begin
            if (sts.build_done) begin
               extract_in = 1'b1;
               state_in   = S_SWAP_R0;
            end else begin
               ctl.op   = skt_pkg::OP_BUILD_NEXT;
               state_in = S_SIFT_ST;
            end
         end
         S_SIFT_ST: begin
            ctl.op   = skt_pkg::OP_SIFT_START;
            state_in = S_SIFT_LD;
         end
         S_SIFT_LD: begin
            ctl.op   = skt_pkg::OP_SIFT_LATCH;
            state_in = S_SIFT_HLD;
         end
         S_SIFT_HLD: begin
            if (sts.sift_has_child) begin
               ctl.op   = skt_pkg::OP_SIFT_RD_HOLD;
               state_in = S_SIFT_CH;
            end else begin
               state_in = S_SIFT_PL;
            end
         end
         S_SIFT_CH: begin
            ctl.op   = skt_pkg::OP_SIFT_RD_CHILD;
            state_in = S_SIFT_CH2;
         end
         S_SIFT_CH2: begin
            ctl.op   = skt_pkg::OP_SIFT_RD_RIGHT;
            state_in = S_SIFT_DEC;
         end
         S_SIFT_DEC: begin
            if (sts.sift_move) begin
               ctl.op   = skt_pkg::OP_SIFT_CMP;
               state_in = S_SIFT_HLD;
            end else begin
               state_in = S_SIFT_PL;
            end
         end
         S_SIFT_PL: begin
            ctl.op   = skt_pkg::OP_SIFT_PLACE;
            state_in = extract_ff ? S_SWAP_R0 : S_BUILD;
         end
         S_SWAP_R0: begin
            if (sts.extract_done) begin
               done = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctl.op   = skt_pkg::OP_SWAP_RD;
               state_in = S_SWAP_R1;
            end
         end
         S_SWAP_R1: begin
            ctl.op   = skt_pkg::OP_SWAP_RD;
            state_in = S_SWAP_W0;
         end
         S_SWAP_W0: begin
            ctl.op   = skt_pkg::OP_SWAP_WR0;
            state_in = S_SWAP_WI;
         end
         S_SWAP_WI: begin
            ctl.op   = skt_pkg::OP_SWAP_WRI;
            state_in = S_SIFT_ST;
         end
         S_FIND_RD: begin
            if (sts.find_active) begin
               ctl.op   = skt_pkg::OP_FIND_RD;
               state_in = S_FIND_CMP;
            end else begin
               status_in = skt_pkg::ST_NOT_FOUND;
               done      = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_FIND_CMP: begin
            if (sts.find_hit) begin
               pay_in   = found_payload;
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctl.op   = skt_pkg::OP_FIND_CMP;
               state_in = S_FIND_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         extract_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         extract_ff   <= extract_in;
      end
      status_ff    <= status_in;
      pay_ff       <= pay_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_found_payload = pay_ff;
endmodule

/* rtl/core/sorted_key_table_heapsort_search.sv */
// sorted_key_table_heapsort_search: top level of the keyed entry table.
// Depends on skt_pkg, skt_ctrl, skt_datapath and skt_ram.
`timescale 1ns / 1ps
// Keyed table with insert, in-place heap sort and binary search. One
// request gives one response. Find makes up to log2(CAPACITY)+1 probes.
// Sort works in place through the single table memory port.
// A new request is taken only after the previous response has been taken.
module sorted_key_table_heapsort_search #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_key,
   input  logic [31:0]        req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_found_payload
);
   skt_pkg::ctl_type ctl;
   skt_pkg::sts_type sts;
   logic [31:0]      found_payload;

   skt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_found_payload(rsp_found_payload),
      .found_payload(found_payload), .sts(sts), .ctl(ctl));

   skt_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl),
      .req_key(req_key), .req_payload(req_payload),
      .sts(sts), .found_payload(found_payload));

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != skt_pkg::ST_RSVD) else $error("bad status");
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != skt_pkg::ST_OK) |-> rsp_found_payload == '0)
      else $error("payload on failed request");
endmodule

/* test/sorted_key_table_heapsort_search_tb.sv */
// Testbench for sorted_key_table_heapsort_search: insert, heap sort and find
// checked against an in-bench table predictor. Depends on skt_pkg and the RTL.
`timescale 1ns / 1ps
module sorted_key_table_heapsort_search_tb;
   localparam int CAP = 256;
   localparam int WATCHDOG = 400000;

   typedef struct packed {
      skt_pkg::cmd_type cmd;
      logic [31:0]      key;
      logic [31:0]      payload;
   } request_type;

   typedef struct packed {
      skt_pkg::status_type status;
      logic [31:0]         payload;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = '0;
   logic signed [31:0] req_key = '0;
   logic [31:0] req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [31:0] rsp_found_payload;

   sorted_key_table_heapsort_search #(.CAPACITY(CAP)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_key(req_key), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_found_payload(rsp_found_payload)
   );

   always #2 clock = ~clock;

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   logic [31:0] tbl_key[CAP];
   logic [31:0] tbl_pay[CAP];
   int tbl_count = 0;
   int errors = 0;
   int idle_cycles = 0;
   bit stall_go = 1'b0;

   function automatic void sift(int pos, int len);
      logic [31:0] hk, hp;
      int c;
      hk = tbl_key[pos];
      hp = tbl_pay[pos];
      while (2 * pos + 1 < len) begin
         c = 2 * pos + 1;
         if (c != len - 1 && $signed(tbl_key[c]) < $signed(tbl_key[c + 1])) c++;
         if ($signed(hk) < $signed(tbl_key[c])) begin
            tbl_key[pos] = tbl_key[c];
            tbl_pay[pos] = tbl_pay[c];
            pos = c;
         end else begin
            break;
         end
      end
      tbl_key[pos] = hk;
      tbl_pay[pos] = hp;
   endfunction

   function automatic answer_type table_apply(request_type r);
      answer_type a;
      logic [31:0] t;
      int lo, hi, i;
      a.status = skt_pkg::ST_OK;
      a.payload = '0;
      case (r.cmd)
         skt_pkg::CMD_INSERT: begin
            if (tbl_count >= CAP) begin
               a.status = skt_pkg::ST_FULL;
            end else begin
               tbl_key[tbl_count] = r.key;
               tbl_pay[tbl_count] = r.payload;
               tbl_count++;
            end
         end
         skt_pkg::CMD_SORT: begin
            if (tbl_count >= 2) begin
               for (i = tbl_count / 2; i >= 0; i--)
                  if (i < tbl_count) sift(i, tbl_count);
               for (i = tbl_count - 1; i > 0; i--) begin
                  t = tbl_key[0]; tbl_key[0] = tbl_key[i]; tbl_key[i] = t;
                  t = tbl_pay[0]; tbl_pay[0] = tbl_pay[i]; tbl_pay[i] = t;
                  sift(0, i);
               end
            end
         end
         skt_pkg::CMD_FIND: begin
            lo = 0;
            hi = tbl_count;
            i = tbl_count / 2;
            a.status = skt_pkg::ST_NOT_FOUND;
            while (i >= lo && i < hi) begin
               if (tbl_key[i] == r.key) begin
                  a.status = skt_pkg::ST_OK;
                  a.payload = tbl_pay[i];
                  break;
               end
               if ($signed(tbl_key[i]) < $signed(r.key)) begin
                  lo = i + 1;
                  i = (i + hi) / 2;
               end else begin
                  hi = i;
                  i = (lo + hi) / 2;
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic void push(skt_pkg::cmd_type c, logic [31:0] k, logic [31:0] p);
      request_type r;
      r.cmd = c;
      r.key = k;
      r.payload = p;
      pending_requests.push_back(r);
   endfunction

   // driver
   int send_gap = 0;
   bit req_taken = 1'b0;
   always @(posedge clock) req_taken <= req_valid && req_ready;

   always @(negedge clock) begin
      request_type r;
      if (!reset) begin
         if (req_taken) begin
            req_valid <= 1'b0;
            send_gap = $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
         end else if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() > 0) begin
               r = pending_requests.pop_front();
               req_cmd <= r.cmd;
               req_key <= r.key;
               req_payload <= r.payload;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // a valid held through acceptance is lowered at the next negedge; refill then
   // comes at a later negedge, which keeps one assignment per step

   // receiver readiness
   int recv_gap = 0;
   int hold_off = 0;
   bit stall_seen = 1'b0;
   bit rsp_taken = 1'b0;
   always @(posedge clock) rsp_taken <= rsp_valid && rsp_ready;

   always @(negedge clock) begin
      if (!reset) begin
         if (stall_go && !stall_seen) begin
            stall_seen = 1'b1;
            hold_off = 300;
            rsp_ready <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else if (rsp_taken) begin
            recv_gap = $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0) recv_gap = 0;
            rsp_ready <= (recv_gap == 0);
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= (recv_gap == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: predict on request, check on response
   always @(posedge clock) begin
      request_type r;
      answer_type e;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            r.cmd = skt_pkg::cmd_type'(req_cmd);
            r.key = req_key;
            r.payload = req_payload;
            expected_answers.push_back(table_apply(r));
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (expected_answers.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response status=%0d payload=%h",
                           rsp_status, rsp_found_payload);
            end else begin
               e = expected_answers.pop_front();
               if (rsp_status !== e.status || rsp_found_payload !== e.payload) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp status=%0d payload=%h, got %0d %h",
                              e.status, e.payload, rsp_status, rsp_found_payload);
               end
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_key(int mode);
      case (mode)
         0: return $urandom_range(0, 40) - 20;
         1: return $urandom();
         default: return 32'h8000_0000 + $urandom_range(0, 3) - 2;
      endcase
   endfunction

   int stored_keys[$];

   task automatic random_phase(int n_insert, int n_find);
      int m;
      m = $urandom_range(0, 2);
      for (int i = 0; i < n_insert; i++) begin
         stored_keys.push_back(rand_key(m));
         push(skt_pkg::CMD_INSERT, stored_keys[$], $urandom());
      end
      if ($urandom_range(0, 7) != 0) push(skt_pkg::CMD_SORT, $urandom(), $urandom());
      for (int i = 0; i < n_find; i++) begin
         if (stored_keys.size() > 0 && $urandom_range(0, 2) != 0)
            push(skt_pkg::CMD_FIND,
                 stored_keys[$urandom_range(0, stored_keys.size() - 1)], $urandom());
         else
            push(skt_pkg::CMD_FIND, rand_key(m), $urandom());
         if ($urandom_range(0, 15) == 0)
            push(skt_pkg::cmd_type'($urandom_range(0, 3)), $urandom(), $urandom());
      end
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, unknown command, single entry, extremes
      push(skt_pkg::CMD_FIND, 32'd0, 32'hFFFF_FFFF);
      push(skt_pkg::CMD_SORT, 32'd0, 32'd0);
      push(skt_pkg::CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push(skt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push(skt_pkg::CMD_SORT, 32'd0, 32'd0);
      push(skt_pkg::CMD_FIND, 32'h7FFF_FFFF, 32'd0);
      push(skt_pkg::CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
      push(skt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
      push(skt_pkg::CMD_INSERT, 32'h0000_0000, 32'h5A5A_A5A5);
      push(skt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
      push(skt_pkg::CMD_FIND, 32'h8000_0000, 32'd0);
      push(skt_pkg::CMD_SORT, 32'd0, 32'd0);
      push(skt_pkg::CMD_FIND, 32'h8000_0000, 32'd0);
      push(skt_pkg::CMD_FIND, 32'h7FFF_FFFF, 32'd0);
      push(skt_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'd0);
      push(skt_pkg::CMD_FIND, 32'h0000_0001, 32'd0);
      push(skt_pkg::CMD_SORT, 32'd0, 32'd0);
      push(skt_pkg::CMD_FIND, 32'h0000_0000, 32'd0);
      drain();

      // long receiver stall while requests keep coming
      for (int i = 0; i < 12; i++) push(skt_pkg::CMD_INSERT, $urandom(), $urandom());
      stall_go = 1'b1;
      drain();

      // fill to capacity, then overflow
      while (stored_keys.size() < CAP - 5) stored_keys.push_back(0);
      for (int i = 0; i < CAP - 17 + 3; i++)
         push(skt_pkg::CMD_INSERT, $urandom_range(0, 500), $urandom());
      push(skt_pkg::CMD_SORT, 32'd0, 32'd0);
      for (int i = 0; i < 20; i++) push(skt_pkg::CMD_FIND, $urandom_range(0, 500), 32'd0);
      drain();

      // remaining random phases run on the full table; table can't be cleared,
      // so this relies on the table being full: inserts now return full
      stored_keys.delete();
      for (int ph = 0; ph < 21; ph++) begin
         random_phase($urandom_range(0, 4), $urandom_range(10, 40));
         drain();
      end
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
